[rtl/awsr_pkg.sv]
`default_nettype none

package awsr_pkg;

  localparam int LETTER_W = 5;
  localparam int MODE_W   = 2;
  localparam int POS_W    = 32;

  localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // classified transaction handed from the front to the back
  typedef struct packed {
    op_e                 op;
    logic [LETTER_W-1:0] letter;
    logic                foreign;
  } item_t;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] start;
    logic             rejected;
  } res_t;

endpackage

`default_nettype wire

[rtl/awsr_ram.sv]
`default_nettype none

module awsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/awsr_fifo.sv]
`default_nettype none

module awsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o,
  output logic      [CNT_W-1:0] count_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[rtl/awsr_front.sv]
`default_nettype none

module awsr_front #(
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire logic [awsr_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [awsr_pkg::LETTER_W-1:0] letter_i,
  output logic                               full_o,
  output awsr_pkg::item_t                    item_o,
  output logic                               item_valid_o,
  input  wire logic                          item_pop_i
);

  localparam int IW = $bits(awsr_pkg::item_t);

  awsr_pkg::item_t cls;
  logic [IW-1:0]   head;
  logic            empty;

  always_comb begin
    cls.letter  = letter_i;
    cls.foreign = (32'(letter_i) >= 32'(ALPHABET_SIZE));
    unique case (mode_i)
      awsr_pkg::MODE_CLEAR:   cls.op = awsr_pkg::OP_CLEAR;
      awsr_pkg::MODE_PATTERN: cls.op = awsr_pkg::OP_PATTERN;
      awsr_pkg::MODE_TEXT:    cls.op = awsr_pkg::OP_TEXT;
      awsr_pkg::MODE_UNUSED:  cls.op = awsr_pkg::OP_NOP;
      default:                cls.op = awsr_pkg::OP_NOP;
    endcase
  end

  awsr_fifo #(
    .WIDTH (IW),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (item_pop_i),
    .data_o  (head),
    .empty_o (empty),
    .count_o ()
  );

  assign item_o       = awsr_pkg::item_t'(head);
  assign item_valid_o = !empty;

endmodule

`default_nettype wire

[rtl/awsr_back.sv]
`default_nettype none

module awsr_back #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  awsr_pkg::item_t                 item_i,
  input  wire logic                       item_valid_i,
  output logic                            item_pop_o,
  output awsr_pkg::res_t                  res_o,
  output logic                            empty_o,
  input  wire logic                       pop_i
);

  localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
  localparam int SLOT_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BK_W      = $clog2(ALPHABET_SIZE + 1);
  localparam int NBK       = ALPHABET_SIZE + 1;
  localparam int CD_W      = LEN_W + 1;
  localparam int POS_W     = awsr_pkg::POS_W;
  localparam int OUT_DEPTH = 4;
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);
  localparam int RW        = $bits(awsr_pkg::res_t);

  // issue stage state
  logic [LEN_W-1:0]  pat_len_q, pat_len_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic              issue;
  logic [BK_W-1:0]   bucket_a;
  logic              pat_ok_a, add_old_a, full_a;
  logic [LEN_W:0]    slot_ext, len_ext, old_ext;
  logic [SLOT_W-1:0] old_slot;
  logic [POS_W:0]    pos_plus, start_ext;
  logic [OCNT_W:0]   inflight;
  logic [OCNT_W-1:0] out_cnt;
  logic              out_full;

  // update stage
  logic                 b_valid_q;
  awsr_pkg::op_e        b_op_q;
  logic [BK_W-1:0]      b_bucket_q;
  logic                 b_pat_ok_q, b_add_old_q, b_full_q;
  logic [POS_W-1:0]     b_start_q;
  logic [BK_W-1:0]      old_bucket;

  // count differences, two's complement, one lane per bucket
  logic [CD_W-1:0]      cd_q [NBK];
  logic [CD_W-1:0]      cd_d [NBK];
  logic [NBK-1:0]       nz_d;
  awsr_pkg::res_t       res_b;

  assign inflight = {1'b0, out_cnt} + {{OCNT_W{1'b0}}, b_valid_q};
  // never issue more than the result queue can take, so the pipe never stalls
  assign issue      = item_valid_i && (inflight < (OCNT_W + 1)'(OUT_DEPTH));
  assign item_pop_o = issue;

  assign bucket_a  = item_i.foreign ? BK_W'(ALPHABET_SIZE) : BK_W'(item_i.letter);
  assign pat_ok_a  = (pos_q == '0) && (pat_len_q < LEN_W'(MAX_PATTERN)) && !item_i.foreign;
  assign add_old_a = (pat_len_q != '0) && (32'(pat_len_q) <= pos_q);

  assign slot_ext = (LEN_W + 1)'(slot_q);
  assign len_ext  = (LEN_W + 1)'(pat_len_q);
  assign old_ext  = (slot_ext >= len_ext) ? slot_ext - len_ext
                                          : slot_ext + (LEN_W + 1)'(MAX_PATTERN) - len_ext;
  assign old_slot = old_ext[SLOT_W-1:0];

  assign pos_plus  = {1'b0, pos_q} + (POS_W + 1)'(1);
  assign full_a    = (pat_len_q != '0) && (pos_plus >= (POS_W + 1)'(pat_len_q));
  assign start_ext = pos_plus - (POS_W + 1)'(pat_len_q);

  always_comb begin
    pat_len_d = pat_len_q;
    pos_d     = pos_q;
    slot_d    = slot_q;
    if (issue) begin
      unique case (item_i.op)
        awsr_pkg::OP_CLEAR: begin
          pat_len_d = '0;
          pos_d     = '0;
          slot_d    = '0;
        end
        awsr_pkg::OP_PATTERN: begin
          if (pat_ok_a) begin
            pat_len_d = pat_len_q + LEN_W'(1);
          end
        end
        awsr_pkg::OP_TEXT: begin
          slot_d = (slot_q == SLOT_W'(MAX_PATTERN - 1)) ? '0 : slot_q + SLOT_W'(1);
          if (pos_q != '1) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
        awsr_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= '0;
      pos_q     <= '0;
      slot_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      pat_len_q <= pat_len_d;
      pos_q     <= pos_d;
      slot_q    <= slot_d;
      b_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_op_q      <= item_i.op;
      b_bucket_q  <= bucket_a;
      b_pat_ok_q  <= pat_ok_a;
      b_add_old_q <= add_old_a;
      b_full_q    <= full_a;
      b_start_q   <= start_ext[POS_W-1:0];
    end
  end

  // history of recent buckets; the leaving letter is read at issue, ahead of the count update
  awsr_ram #(
    .WIDTH (BK_W),
    .DEPTH (MAX_PATTERN)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (issue && (item_i.op == awsr_pkg::OP_TEXT)),
    .waddr_i (slot_q),
    .wdata_i (bucket_a),
    .raddr_i (old_slot),
    .rdata_o (old_bucket)
  );

  always_comb begin
    logic inc, dec;
    for (int j = 0; j < NBK; j++) begin
      inc = b_valid_q &&
            (((b_op_q == awsr_pkg::OP_TEXT) && b_add_old_q && (old_bucket == BK_W'(j))) ||
             ((b_op_q == awsr_pkg::OP_PATTERN) && b_pat_ok_q && (b_bucket_q == BK_W'(j))));
      dec = b_valid_q && (b_op_q == awsr_pkg::OP_TEXT) && (b_bucket_q == BK_W'(j));
      if (b_valid_q && (b_op_q == awsr_pkg::OP_CLEAR)) begin
        cd_d[j] = '0;
      end else begin
        cd_d[j] = cd_q[j] + CD_W'(inc) - CD_W'(dec);
      end
      nz_d[j] = (cd_d[j] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NBK; j++) begin
        cd_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < NBK; j++) begin
        cd_q[j] <= cd_d[j];
      end
    end
  end

  // no bucket differing stands for a zero differing-letter count
  always_comb begin
    res_b.match    = (b_op_q == awsr_pkg::OP_TEXT) && b_full_q && !(|nz_d);
    res_b.start    = res_b.match ? b_start_q : '0;
    res_b.rejected = (b_op_q == awsr_pkg::OP_PATTERN) && !b_pat_ok_q;
  end

  logic [RW-1:0] res_head;

  awsr_fifo #(
    .WIDTH (RW),
    .DEPTH (OUT_DEPTH)
  ) u_results (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .data_i  (res_b),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .data_o  (res_head),
    .empty_o (empty_o),
    .count_o (out_cnt)
  );

  assign res_o = awsr_pkg::res_t'(res_head);

`ifndef ASSERT_OFF
  a_no_result_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> !out_full)
    else $error("result queue pushed while full");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(slot_q) < 32'(MAX_PATTERN))
    else $error("history slot out of range");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (item_i.op == awsr_pkg::OP_CLEAR)) |=>
      ((pos_q == '0) && (pat_len_q == '0) && (slot_q == '0)))
    else $error("clear left issue state behind");

  a_late_pattern_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && (item_i.op == awsr_pkg::OP_PATTERN) && (pos_q != '0)) |=>
      (pat_len_q == $past(pat_len_q)))
    else $error("pattern grew after text started");
`endif

endmodule

`default_nettype wire

[rtl/anagram_window_search.sv]
// Path: front queue, then the registered update stage, then the result queue.
// Throughput: one transaction per cycle while the result queue is popped; each letter takes
//   one history RAM read, issued in the issue stage ahead of the count update.
// Reset (rst_ni, asynchronous, active low) clears counts, lengths, position and queues at
//   once; the history RAM is not cleared and needs no clearing pass.
`default_nettype none

module anagram_window_search #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [awsr_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [awsr_pkg::LETTER_W-1:0] letter_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               match_o,
  output logic      [awsr_pkg::POS_W-1:0]    start_index_o,
  output logic                               rejected_o
);

  awsr_pkg::item_t item;
  logic            item_valid;
  logic            item_pop;
  awsr_pkg::res_t  res;

  awsr_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .mode_i       (mode_i),
    .letter_i     (letter_i),
    .full_o       (full),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  awsr_back #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .res_o        (res),
    .empty_o      (empty),
    .pop_i        (pop)
  );

  assign match_o       = res.match;
  assign start_index_o = res.start;
  assign rejected_o    = res.rejected;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MAX_PAT     = 64;
  localparam int ALPHABET    = 26;
  localparam int RANDOM_ITEMS = 1000;
  localparam int DIRECTED    = 22;
  localparam int STALL_LIMIT = 1000;

  logic                          clk = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [awsr_pkg::MODE_W-1:0]   mode_i = awsr_pkg::MODE_CLEAR;
  logic [awsr_pkg::LETTER_W-1:0] letter_i = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          match_o;
  logic [awsr_pkg::POS_W-1:0]    start_index_o;
  logic                          rejected_o;

  bit calm = 1'b0;
  bit no_gaps = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  anagram_window_search #(
    .MAX_PATTERN   (MAX_PAT),
    .ALPHABET_SIZE (ALPHABET)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .mode_i        (mode_i),
    .letter_i      (letter_i),
    .empty         (empty),
    .pop           (pop),
    .match_o       (match_o),
    .start_index_o (start_index_o),
    .rejected_o    (rejected_o)
  );

  // Tracks letter counts of pattern against window and holds the results still owed.
  class anagram_tracker;
    int signed                  diff [ALPHABET+1];
    int unsigned                mismatched;
    int unsigned                pat_len;
    logic [4:0]                 history [MAX_PAT];
    logic [awsr_pkg::POS_W-1:0] pos;
    int unsigned                slot;
    awsr_pkg::res_t             awaited [$];
    int                         failures;

    function new();
      failures = 0;
      wipe();
    endfunction

    function void wipe();
      foreach (diff[i]) diff[i] = 0;
      foreach (history[i]) history[i] = '0;
      mismatched = 0;
      pat_len = 0;
      pos = '0;
      slot = 0;
    endfunction

    function void bump(int b, int delta);
      bit was_off;
      was_off = diff[b] != 0;
      diff[b] += delta;
      if (was_off && diff[b] == 0) mismatched--;
      else if (!was_off && diff[b] != 0) mismatched++;
    endfunction

    function void note_item(logic [awsr_pkg::MODE_W-1:0] mode,
                            logic [awsr_pkg::LETTER_W-1:0] letter);
      awsr_pkg::res_t           res;
      int                       b;
      int unsigned              old;
      logic [awsr_pkg::POS_W:0] span_end;
      res = '0;
      case (mode)
        awsr_pkg::MODE_CLEAR: begin
          wipe();
        end
        awsr_pkg::MODE_PATTERN: begin
          if (pos != 0 || pat_len >= MAX_PAT || letter >= ALPHABET) begin
            res.rejected = 1'b1;
          end else begin
            bump(int'(letter), 1);
            pat_len++;
          end
        end
        awsr_pkg::MODE_TEXT: begin
          b = (letter < ALPHABET) ? int'(letter) : ALPHABET;
          // letter leaving the window goes back into the pattern's favour
          if (pat_len > 0 && pos >= pat_len) begin
            old = (slot >= pat_len) ? slot - pat_len : slot + MAX_PAT - pat_len;
            bump(int'(history[old]), 1);
          end
          bump(b, -1);
          history[slot] = 5'(b);
          slot = (slot + 1 >= MAX_PAT) ? 0 : slot + 1;
          span_end = {1'b0, pos} + 1'b1;
          if (pat_len > 0 && span_end >= pat_len && mismatched == 0) begin
            res.match = 1'b1;
            res.start = awsr_pkg::POS_W'(span_end - pat_len);
          end
          if (pos != '1) pos++;
        end
        awsr_pkg::MODE_UNUSED: begin
        end
        default: begin
        end
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(logic m, logic [awsr_pkg::POS_W-1:0] s, logic r);
      awsr_pkg::res_t e;
      if (awaited.size() == 0) begin
        $error("result arrived with nothing awaited");
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (m !== e.match) begin
        $error("match: expected %0d, actual %0d", e.match, m);
        failures++;
      end
      if (s !== e.start) begin
        $error("start_index: expected %0d, actual %0d", e.start, s);
        failures++;
      end
      if (r !== e.rejected) begin
        $error("rejected: expected %0d, actual %0d", e.rejected, r);
        failures++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  anagram_tracker tracker = new();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side
  always @(posedge clk) begin
    if (rst_ni && pop && !empty) tracker.check_result(match_o, start_index_o, rejected_o);
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!calm && !no_gaps && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [awsr_pkg::MODE_W-1:0] mode,
                           input logic [awsr_pkg::LETTER_W-1:0] letter);
    if (!calm && !no_gaps && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    push     <= 1'b1;
    mode_i   <= mode;
    letter_i <= letter;
    do @(posedge clk); while (full);
    tracker.note_item(mode, letter);
    if (mode != awsr_pkg::MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [awsr_pkg::LETTER_W-1:0] pick_letter(int base, int span);
    return awsr_pkg::LETTER_W'((base + $urandom_range(0, span - 1)) % ALPHABET);
  endfunction

  task automatic run_sequence();
    logic [awsr_pkg::LETTER_W-1:0] pat [$];
    logic [awsr_pkg::LETTER_W-1:0] perm [$];
    logic [awsr_pkg::LETTER_W-1:0] tmp;
    int base, span, plen, tlen, fed, pick, j, k;
    calm = no_gaps || ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 7) != 0) begin
      send_item(awsr_pkg::MODE_CLEAR, awsr_pkg::LETTER_W'($urandom_range(0, 31)));
    end
    base = $urandom_range(0, ALPHABET - 1);
    span = $urandom_range(1, 5);
    pick = $urandom_range(0, 19);
    if (pick == 0) plen = 0;
    else if (pick == 1) plen = $urandom_range(60, 70);
    else plen = $urandom_range(1, 6);
    for (j = 0; j < plen; j++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(awsr_pkg::MODE_PATTERN, awsr_pkg::LETTER_W'($urandom_range(ALPHABET, 31)));
      end else begin
        tmp = pick_letter(base, span);
        send_item(awsr_pkg::MODE_PATTERN, tmp);
        if (pat.size() < MAX_PAT) pat.push_back(tmp);
      end
    end
    tlen = plen + $urandom_range(4, 40);
    fed = 0;
    while (fed < tlen) begin
      pick = $urandom_range(0, 9);
      if (pick < 5 && pat.size() > 0) begin
        // shuffled copy of the pattern gives a window that should match
        perm = pat;
        for (j = perm.size() - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          tmp = perm[j];
          perm[j] = perm[k];
          perm[k] = tmp;
        end
        foreach (perm[i]) send_item(awsr_pkg::MODE_TEXT, perm[i]);
        fed += perm.size();
      end else if (pick < 8) begin
        send_item(awsr_pkg::MODE_TEXT, pick_letter(base, span));
        fed++;
      end else if (pick == 8) begin
        send_item(awsr_pkg::MODE_TEXT, awsr_pkg::LETTER_W'($urandom_range(0, 31)));
        fed++;
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(awsr_pkg::MODE_UNUSED, awsr_pkg::LETTER_W'($urandom_range(0, 31)));
      end else begin
        send_item(awsr_pkg::MODE_PATTERN, awsr_pkg::LETTER_W'($urandom_range(0, 31)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // directed: unused mode, empty pattern, extremes, foreign letters, late pattern letter
    send_item(awsr_pkg::MODE_CLEAR, 5'd0);
    send_item(awsr_pkg::MODE_UNUSED, 5'd31);
    send_item(awsr_pkg::MODE_TEXT, 5'd0);
    send_item(awsr_pkg::MODE_CLEAR, 5'd31);
    send_item(awsr_pkg::MODE_PATTERN, 5'd0);
    send_item(awsr_pkg::MODE_PATTERN, 5'd25);
    send_item(awsr_pkg::MODE_PATTERN, 5'd31);
    send_item(awsr_pkg::MODE_TEXT, 5'd25);
    send_item(awsr_pkg::MODE_TEXT, 5'd0);
    send_item(awsr_pkg::MODE_TEXT, 5'd25);
    send_item(awsr_pkg::MODE_TEXT, 5'd31);
    send_item(awsr_pkg::MODE_TEXT, 5'd0);
    send_item(awsr_pkg::MODE_TEXT, 5'd25);
    send_item(awsr_pkg::MODE_PATTERN, 5'd0);
    send_item(awsr_pkg::MODE_CLEAR, 5'd0);
    send_item(awsr_pkg::MODE_PATTERN, 5'd1);
    send_item(awsr_pkg::MODE_PATTERN, 5'd1);
    send_item(awsr_pkg::MODE_PATTERN, 5'd2);
    send_item(awsr_pkg::MODE_TEXT, 5'd1);
    send_item(awsr_pkg::MODE_TEXT, 5'd2);
    send_item(awsr_pkg::MODE_TEXT, 5'd1);
    send_item(awsr_pkg::MODE_UNUSED, 5'd0);

    while (items_sent < DIRECTED + RANDOM_ITEMS) begin
      if (items_sent >= DIRECTED + RANDOM_ITEMS - 150) no_gaps = 1'b1;
      run_sequence();
    end
    push <= 1'b0;

    while (tracker.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[anagram_window_search.f]
rtl/awsr_pkg.sv
rtl/awsr_ram.sv
rtl/awsr_fifo.sv
rtl/awsr_front.sv
rtl/awsr_back.sv
rtl/anagram_window_search.sv
test/tb.sv
